// ----- hdl/mads_pkg.sv -----
// Shared types, codes and default sizes for the anti-diagonal scan buffer.
// No dependencies; imported by every module of the block except mads_ram.
package mads_pkg;

	// Default sizes handed to the top level parameters
	localparam int MAX_DIM_DEF   = 64;
	localparam int MAX_ELEMS_DEF = 4096;

	// Fixed field widths
	localparam int ELEM_W     = 32;
	localparam int DIM_W      = 7;          // row_count / col_count registers
	localparam int DIAG_W     = DIM_W + 1;  // diagonal index up to rows+cols-2
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DIM_W;

	// Result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	// Request function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EMIT = 1'b1;

	// Result status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NODATA = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic                     func;
		logic signed [ELEM_W-1:0] element;
	} req_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element_out;
		logic                     last;
		logic                     status;
	} res_t;

	// Controller -> datapath
	typedef struct packed {
		logic store;   // write element, bump load count
		logic read;    // read scan element
		logic step;    // advance scan position
		logic clear;   // clear all counters
		logic nodata;  // queue a no-data result
		logic last;    // read is the final element
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic full;        // load count reached matrix size
		logic load_final;  // next load fills the matrix
		logic beyond;      // diagonal index past the last diagonal
		logic at_last;     // current diagonal is the last one
		logic room;        // result queue can take one more request
	} sts_t;

	typedef enum logic [1:0] {
		ST_SYNC,
		ST_LOAD,
		ST_SCAN
	} state_t;

endpackage

// ----- hdl/matrix_antidiagonal_scan.sv -----
// Top level of the anti-diagonal scan buffer: ports, configuration handshake,
// controller and datapath. Depends on mads_pkg, mads_ctrl, mads_dp.
//
// Usage: configure row_count (index 0) and col_count (index 1) over the cfg
// channel (cfg_ready is always high). Then send rows*cols load requests
// (func 0) carrying elements in row-major order, followed by emit requests
// (func 1). Each emit returns one result: the next element in anti-diagonal
// order, with last set on the final one, after which the counters clear for
// the next matrix. Emits before the matrix is complete return status 1 with
// zero data; loads into a full matrix are dropped and return nothing.
// Throughput: one request per cycle while req_stall is low. An emit's result
// is read from the registered element store and then written into the
// four-entry result queue. When the receiver stalls, the queue fills and
// req_stall rises once queued plus in-flight results reach four.
// Reset clears counters and sets a 1x1 matrix; the store is not cleared.
// req_stall is high for one cycle after reset and after each register
// write while the load/scan phase is re-evaluated.
module matrix_antidiagonal_scan #(
	parameter int MAX_DIM   = mads_pkg::MAX_DIM_DEF,
	parameter int MAX_ELEMS = mads_pkg::MAX_ELEMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  mads_pkg::req_t                  req,
	// result channel
	output logic                            res_valid,
	input  logic                            res_stall,
	output mads_pkg::res_t                  res,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mads_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mads_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mads_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	mads_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.func     (req.func),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.cmd      (cmd),
		.stall    (req_stall)
	);

	mads_dp #(
		.MAX_DIM  (MAX_DIM),
		.MAX_ELEMS(MAX_ELEMS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.element  (req.element),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sts      (sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

// ----- hdl/mads_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mads_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/mads_ctrl.sv -----
// Controller for the anti-diagonal scan buffer: load/scan phase tracking,
// request decode and flow control. Depends on mads_pkg.
module mads_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            func,
	input  logic            cfg_we,
	input  mads_pkg::sts_t  sts,
	output mads_pkg::cmd_t  cmd,
	output logic            stall
);
	import mads_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC;
		end else begin
			state_q <= state_d;
		end
	end

	// No request taken in the sync cycle after reset or a register write
	assign stall  = (state_q == ST_SYNC) || !sts.room;
	assign accept = req_valid && !stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_SYNC: begin
				state_d = sts.full ? ST_SCAN : ST_LOAD;
			end
			ST_LOAD: begin
				if (accept) begin
					if (func == FUNC_LOAD) begin
						cmd.store = 1'b1;
						if (sts.load_final) begin
							state_d = ST_SCAN;
						end
					end else begin
						cmd.nodata = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// loads into a full store are dropped
				if (accept && func == FUNC_EMIT) begin
					if (sts.beyond) begin
						cmd.clear  = 1'b1;
						cmd.nodata = 1'b1;
						state_d    = ST_LOAD;
					end else if (sts.at_last) begin
						cmd.read  = 1'b1;
						cmd.last  = 1'b1;
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						cmd.read = 1'b1;
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_SYNC;
			end
		endcase
		// dimensions changed: re-evaluate the phase
		if (cfg_we) begin
			state_d = ST_SYNC;
		end
	end

	// Assertions
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYNC) |-> (cmd == '0))
		else $error("command issued during sync cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == ST_SYNC))
		else $error("phase not resynced after register write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store && sts.load_final) |=> (state_q == ST_SCAN || state_q == ST_SYNC))
		else $error("scan phase not entered after final load");

endmodule

// ----- hdl/mads_dp.sv -----
// Datapath of the anti-diagonal scan buffer: dimension registers, load and
// scan counters, element store, result queue. Depends on mads_pkg, mads_ram.
module mads_dp #(
	parameter int MAX_DIM   = mads_pkg::MAX_DIM_DEF,
	parameter int MAX_ELEMS = mads_pkg::MAX_ELEMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mads_pkg::cmd_t                     cmd,
	input  logic signed [mads_pkg::ELEM_W-1:0] element,
	input  logic                               cfg_we,
	input  logic [mads_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mads_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mads_pkg::sts_t                     sts,
	output logic                               res_valid,
	input  logic                               res_stall,
	output mads_pkg::res_t                     res
);
	import mads_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
	localparam int AW     = $clog2(MAX_ELEMS);
	localparam int PROD_W = 2 * DIM_W;
	localparam int SUM_W  = (AW > PROD_W + 1) ? AW : PROD_W + 1;
	localparam int DimMax = 2 ** DIM_W - 1;
	localparam int ColLimRaw = (MAX_DIM < MAX_ELEMS) ? MAX_DIM : MAX_ELEMS;
	localparam int ColLim = (ColLimRaw > DimMax) ? DimMax : ColLimRaw;

	// ---------------- dimension registers ----------------
	logic [DIM_W-1:0]  row_cnt_q, col_cnt_q;
	logic [DIM_W-1:0]  row_raw, col_raw;
	logic [DIM_W-1:0]  rows_n, cols_n, rlim;
	logic [PROD_W-1:0] total_prod;
	logic [DIM_W-1:0]  rows_q, cols_q;
	logic [CNT_W-1:0]  total_q;
	logic [DIAG_W-1:0] dmax_q;

	// Row limit per column count: min(MAX_DIM, MAX_ELEMS / cols), capped at 2**DIM_W-1
	logic [DIM_W-1:0] row_lim [2 ** DIM_W];
	for (genvar Cv = 0; Cv < 2 ** DIM_W; Cv++) begin : g_row_lim
		localparam int Lim = (Cv == 0) ? 1 :
			((MAX_ELEMS / Cv < MAX_DIM) ? MAX_ELEMS / Cv : MAX_DIM);
		localparam int LimSat = (Lim > DimMax) ? DimMax : Lim;
		assign row_lim[Cv] = DIM_W'(LimSat);
	end

	// Effective dimensions of the register values after this write
	always_comb begin
		row_raw = row_cnt_q;
		col_raw = col_cnt_q;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_raw = cfg_data;
				REG_COL_COUNT: col_raw = cfg_data;
				default: ;
			endcase
		end
		if (col_raw == '0) begin
			cols_n = DIM_W'(1);
		end else if (int'(col_raw) > ColLim) begin
			cols_n = DIM_W'(ColLim);
		end else begin
			cols_n = col_raw;
		end
		rlim = row_lim[cols_n];
		if (row_raw == '0) begin
			rows_n = DIM_W'(1);
		end else if (row_raw > rlim) begin
			rows_n = rlim;
		end else begin
			rows_n = row_raw;
		end
		total_prod = PROD_W'(rows_n) * PROD_W'(cols_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= DIM_W'(1);
			col_cnt_q <= DIM_W'(1);
			rows_q    <= DIM_W'(1);
			cols_q    <= DIM_W'(1);
			total_q   <= CNT_W'(1);
			dmax_q    <= '0;
		end else if (cfg_we) begin
			row_cnt_q <= row_raw;
			col_cnt_q <= col_raw;
			rows_q    <= rows_n;
			cols_q    <= cols_n;
			total_q   <= CNT_W'(total_prod);
			dmax_q    <= DIAG_W'(rows_n) + DIAG_W'(cols_n) - DIAG_W'(2);
		end
	end

	// ---------------- scan position ----------------
	logic [CNT_W-1:0]  load_q;
	logic [DIAG_W-1:0] diag_q;
	logic [DIM_W-1:0]  row_q;
	logic [DIAG_W-1:0] cols_d, rows_d, row_d;
	logic [DIAG_W-1:0] lo_d, hi_d, r_d, col_d, d_nxt, lo_nxt;
	logic [PROD_W-1:0] row_base;
	logic [SUM_W-1:0]  addr_sum;
	logic [AW-1:0]     rd_addr;

	assign cols_d = DIAG_W'(cols_q);
	assign rows_d = DIAG_W'(rows_q);
	assign row_d  = DIAG_W'(row_q);

	// Row range of the current diagonal, stray row restarts at its first row
	always_comb begin
		lo_d   = (diag_q >= cols_d) ? diag_q - cols_d + DIAG_W'(1) : '0;
		hi_d   = (diag_q < rows_d - DIAG_W'(1)) ? diag_q : rows_d - DIAG_W'(1);
		r_d    = (row_d < lo_d || row_d > hi_d) ? lo_d : row_d;
		col_d  = diag_q - r_d;
		d_nxt  = diag_q + DIAG_W'(1);
		lo_nxt = (d_nxt >= cols_d) ? d_nxt - cols_d + DIAG_W'(1) : '0;
	end

	// Row-major address of (r, d - r)
	assign row_base = PROD_W'(r_d[DIM_W-1:0]) * PROD_W'(cols_q);
	assign addr_sum = SUM_W'(row_base) + SUM_W'(col_d);
	assign rd_addr  = addr_sum[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			diag_q <= '0;
			row_q  <= '0;
		end else if (cmd.clear) begin
			load_q <= '0;
			diag_q <= '0;
			row_q  <= '0;
		end else begin
			if (cmd.store) begin
				load_q <= load_q + CNT_W'(1);
			end
			if (cmd.step) begin
				if (r_d < hi_d) begin
					row_q <= DIM_W'(r_d + DIAG_W'(1));
				end else begin
					diag_q <= d_nxt;
					row_q  <= DIM_W'(lo_nxt);
				end
			end
		end
	end

	// ---------------- element store ----------------
	logic [ELEM_W-1:0] rd_data;

	mads_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(MAX_ELEMS)
	) u_store (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(load_q[AW-1:0]),
		.wdata(element),
		.re   (cmd.read),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// ---------------- read stage and result queue ----------------
	logic                valid_s1, nodata_s1, last_s1;
	res_t                oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic                pop;
	res_t                push_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.read || cmd.nodata;
		end
	end

	always_ff @(posedge clk) begin
		nodata_s1 <= cmd.nodata;
		last_s1   <= cmd.last;
	end

	always_comb begin
		push_entry.element_out = nodata_s1 ? '0 : rd_data;
		push_entry.last        = last_s1 && !nodata_s1;
		push_entry.status      = nodata_s1 ? STATUS_NODATA : STATUS_OK;
	end

	assign pop = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(valid_s1) - OQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[wr_ptr_q] <= push_entry;
		end
	end

	assign res_valid = (oq_cnt_q != '0);
	assign res       = oq_q[rd_ptr_q];

	// ---------------- status ----------------
	always_comb begin
		sts.full       = (load_q >= total_q);
		sts.load_final = (load_q == total_q - CNT_W'(1));
		sts.beyond     = (diag_q > dmax_q);
		sts.at_last    = (diag_q == dmax_q);
		// queued plus in-flight results leave a free slot
		sts.room       = ((oq_cnt_q + OQ_CNT_W'(valid_s1)) <= OQ_CNT_W'(OQ_DEPTH - 1));
	end

	// Assertions
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (load_q < total_q))
		else $error("store beyond matrix size");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (CNT_W'(rd_addr) < total_q))
		else $error("scan address outside loaded matrix");

	assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (load_q == '0 && diag_q == '0 && row_q == '0))
		else $error("counters not cleared");

endmodule

// ----- dv/matrix_antidiagonal_scan_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the anti-diagonal scan buffer: tracks register writes and
// requests, predicts each scan result and compares it with the result channel.
// Depends on mads_pkg only.
module matrix_antidiagonal_scan_checker #(
	parameter int MAX_DIM   = mads_pkg::MAX_DIM_DEF,
	parameter int MAX_ELEMS = mads_pkg::MAX_ELEMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  mads_pkg::req_t                  req,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  mads_pkg::res_t                  res,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mads_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mads_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import mads_pkg::*;

	// Local copy of the buffer state
	logic signed [ELEM_W-1:0] matrix_copy [MAX_ELEMS];
	int unsigned              loaded;
	int unsigned              diag;
	int unsigned              diag_pos;
	logic [DIM_W-1:0]         rows_reg;
	logic [DIM_W-1:0]         cols_reg;
	res_t                     scan_results_due [$];

	function automatic int unsigned diag_first_row(input int unsigned d, input int unsigned cols);
		return (d >= cols) ? d - cols + 1 : 0;
	endfunction

	function automatic void clear_scan();
		loaded   = 0;
		diag     = 0;
		diag_pos = 0;
	endfunction

	// Apply one request to the local state; an emit queues the result it should give
	task automatic follow_request(input req_t r);
		int unsigned lim, cols, rows, total, dlast, lo, hi, rp, addr;
		res_t        due;
		lim  = (MAX_DIM < MAX_ELEMS) ? MAX_DIM : MAX_ELEMS;
		cols = (cols_reg < 1) ? 1 : (cols_reg > lim) ? lim : cols_reg;
		lim  = MAX_ELEMS / cols;
		if (lim > MAX_DIM)
			lim = MAX_DIM;
		rows  = (rows_reg < 1) ? 1 : (rows_reg > lim) ? lim : rows_reg;
		total = rows * cols;
		dlast = rows + cols - 2;
		if (r.func == FUNC_LOAD) begin
			// loads past the end of the matrix are dropped
			if (loaded < total) begin
				matrix_copy[loaded] = r.element;
				loaded++;
			end
		end else begin
			due.element_out = '0;
			due.last        = 1'b0;
			due.status      = STATUS_NODATA;
			if (loaded >= total) begin
				if (diag > dlast) begin
					// diagonal left behind by a shrink: start over
					clear_scan();
				end else begin
					lo = diag_first_row(diag, cols);
					hi = (diag < rows - 1) ? diag : rows - 1;
					rp = (diag_pos < lo || diag_pos > hi) ? lo : diag_pos;
					addr = rp * cols + (diag - rp);
					due.element_out = (addr < MAX_ELEMS) ? matrix_copy[addr] : '0;
					due.status      = STATUS_OK;
					if (diag == dlast) begin
						due.last = 1'b1;
						clear_scan();
					end else if (rp < hi) begin
						diag_pos = rp + 1;
					end else begin
						diag++;
						diag_pos = diag_first_row(diag, cols);
					end
				end
			end
			scan_results_due.push_back(due);
		end
	endtask

	// Sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_scan();
			rows_reg = DIM_W'(1);
			cols_reg = DIM_W'(1);
			scan_results_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// result side: compare with the oldest prediction
			if (res_valid && !res_stall) begin
				if (scan_results_due.size() == 0) begin
					$display("%0t: result with none due: element %0d last %0b status %0b",
						$time, res.element_out, res.last, res.status);
					mismatches++;
				end else begin
					want = scan_results_due.pop_front();
					if (res.element_out !== want.element_out || res.last !== want.last ||
							res.status !== want.status) begin
						$display("%0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							$time, want.element_out, want.last, want.status,
							res.element_out, res.last, res.status);
						mismatches++;
					end
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROW_COUNT)
					rows_reg = cfg_data;
				else if (cfg_index == REG_COL_COUNT)
					cols_reg = cfg_data;
			end
			// requests
			if (req_valid && !req_stall)
				follow_request(req);
			outstanding <= scan_results_due.size();
		end
	end

endmodule

// ----- dv/matrix_antidiagonal_scan_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the anti-diagonal scan buffer: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on mads_pkg, matrix_antidiagonal_scan and the scan checker.
module matrix_antidiagonal_scan_tb;
	import mads_pkg::*;

	localparam int RANDOM_ITEMS = 1450;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  res_valid;
	logic                  res_stall;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	bit          idling;
	int unsigned rows_set;
	int unsigned cols_set;
	int unsigned sent;

	always #4 clk = ~clk;

	matrix_antidiagonal_scan DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix_antidiagonal_scan_checker CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Dimension the block ends up using for a raw register value
	function automatic int unsigned dim_in_use(input int unsigned raw);
		return (raw < 1) ? 1 : (raw > 64) ? 64 : raw;
	endfunction

	function automatic int unsigned extreme_dim();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 64;
			2: return 127;
			default: return $urandom_range(65, 127);
		endcase
	endfunction

	// One request, after a random gap when idling; holds until accepted
	task automatic send_req(input logic f, input logic [ELEM_W-1:0] e);
		int gap;
		gap = idling ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{func: f, element: e};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_ROW_COUNT)
			rows_set = 32'(val);
		else
			cols_set = 32'(val);
	endtask

	// Stop sending until every result is back, then let the pipeline drain
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Load a whole matrix then scan it, with stray requests mixed in;
	// now and then the matrix is abandoned part way for a register change
	task automatic run_matrix(output bit cut_short);
		int unsigned total, cut;
		logic [ELEM_W-1:0] value;
		total = dim_in_use(rows_set) * dim_in_use(cols_set);
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2 * total) : 0;
		cut_short = 1'b0;
		for (int unsigned i = 0; i < 2 * total && !cut_short && sent < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_req((i < total) ? FUNC_EMIT : FUNC_LOAD, $urandom);
				sent++;
			end
			case ($urandom_range(0, 15))
				0: value = 32'h8000_0000;
				1: value = 32'h7fff_ffff;
				default: value = $urandom;
			endcase
			send_req((i < total) ? FUNC_LOAD : FUNC_EMIT, value);
			sent++;
			if (cut != 0 && i + 1 == cut)
				cut_short = 1'b1;
		end
	endtask

	// Result side: random stall before each result, none when idling is off
	initial begin
		int n;
		res_stall <= 1'b0;
		forever begin
			n = idling ? $urandom_range(0, 15) : 0;
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// Request and register stimulus
	initial begin
		logic [ELEM_W-1:0] edge_vals [6];
		bit cut_short;
		edge_vals = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
			32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001};
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= '0;
		idling    = 1'b1;
		rows_set  = 1;
		cols_set  = 1;
		sent      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1x1 after reset: early emit, load, load into full store, final emit
		send_req(FUNC_EMIT, '0);
		send_req(FUNC_LOAD, 32'h7fff_ffff);
		send_req(FUNC_LOAD, 32'h8000_0000);
		send_req(FUNC_EMIT, '0);

		// 2x3, scan cut by a column change: row restart on the last diagonal
		settle();
		write_reg(REG_ROW_COUNT, CFG_DATA_W'(2));
		write_reg(REG_COL_COUNT, CFG_DATA_W'(3));
		foreach (edge_vals[i])
			send_req(FUNC_LOAD, edge_vals[i]);
		repeat (3) send_req(FUNC_EMIT, '0);
		settle();
		write_reg(REG_COL_COUNT, CFG_DATA_W'(2));
		send_req(FUNC_EMIT, '0);

		// 2x3 again, then shrink so the scan position lies past the last diagonal
		settle();
		write_reg(REG_COL_COUNT, CFG_DATA_W'(3));
		repeat (6) send_req(FUNC_LOAD, $urandom);
		repeat (4) send_req(FUNC_EMIT, '0);
		settle();
		write_reg(REG_COL_COUNT, CFG_DATA_W'(1));
		send_req(FUNC_EMIT, '0);

		// Random phases: new sizes, whole matrices, occasional mid-matrix change
		while (sent < RANDOM_ITEMS) begin
			settle();
			idling = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: begin
					rows_set = extreme_dim();
					cols_set = $urandom_range(1, 3);
				end
				1: begin
					cols_set = extreme_dim();
					rows_set = $urandom_range(1, 3);
				end
				default: begin
					rows_set = $urandom_range(1, 8);
					cols_set = $urandom_range(1, 8);
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows_set));
				write_reg(REG_COL_COUNT, CFG_DATA_W'(cols_set));
			end else begin
				write_reg(REG_COL_COUNT, CFG_DATA_W'(cols_set));
				write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows_set));
			end
			cut_short = 1'b0;
			for (int m = $urandom_range(1, 3); m > 0 && !cut_short; m--)
				run_matrix(cut_short);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
